// File: rtl/core/uvd_pkg.sv
// ----------------------------------------------------------------------------
// uvd_pkg: shared types and constants of the unique value deque
// Operation and status codes, field widths and the sequencer state type.
// ----------------------------------------------------------------------------
package uvd_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int OP_W     = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    localparam logic [VALUE_W-1:0] NOT_FOUND = {VALUE_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_DUP   = 3'd1,
        ST_EMPTY = 3'd2,
        ST_RANGE = 3'd3,
        ST_FULL  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_LATCH,
        S_DONE
    } state_t;

endpackage

// File: rtl/core/unique_value_deque.sv
// ----------------------------------------------------------------------------
// unique_value_deque: bounded queue of distinct 32-bit signed values
// Push at the front with a duplicate check, pop from the back, peek by
// position from the front. One entry memory with one write and one read port, and one comparator.
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals                    Contents
//  s_axis    in         tvalid tready tdata tuser  value, position; operation
//  m_axis    out        tvalid tready tdata tuser  result_value, entry_count; status
//
//  A push scans the held entries in order through the memory read port; a
//  duplicate ends the scan early. A pop or an in-range peek passes S_READ and
//  S_LATCH; an empty pop, a peek past the count and an unused operation go
//  straight to S_DONE. A new transaction is taken only in S_IDLE.
//  Reset clears the count and front pointer; the entry memory is not cleared.
//  A result waits in the output register while the next transaction runs; a full
//  register holds the next result back.
// ----------------------------------------------------------------------------
module unique_value_deque #(
    parameter int DEPTH = uvd_pkg::DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [31:0] value, [35:32] position, [39:36] zero
    input  logic [uvd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [1:0] operation
    input  logic [uvd_pkg::OP_W-1:0]        s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [31:0] result_value, [36:32] entry_count, [39:37] zero
    output logic [uvd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // [2:0] status
    output logic [uvd_pkg::STATUS_W-1:0]    m_axis_tuser
);
    import uvd_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PC_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    state_t               state_reg, state_next;
    logic [AW-1:0]        front_reg, front_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic                 issue_vld_reg, issue_vld_next;
    logic                 out_vld_reg, out_vld_next;

    logic [VALUE_W-1:0]   value_reg, value_next;
    logic [AW-1:0]        addr_reg, addr_next;
    logic                 is_pop_reg, is_pop_next;
    logic [VALUE_W-1:0]   res_reg, res_next;
    status_t              st_reg, st_next;
    logic [VALUE_W-1:0]   out_res_reg, out_res_next;
    status_t              out_st_reg, out_st_next;
    logic [COUNT_W-1:0]   out_cnt_reg, out_cnt_next;

    logic [VALUE_W-1:0]   mem [DEPTH];
    logic [VALUE_W-1:0]   rd_data_reg;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic                 we;

    op_t                  in_op;
    logic [POS_W-1:0]     in_pos;
    logic [AW-1:0]        front_dec;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(DEPTH))
        begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return AW'(sum);
    endfunction

    assign in_op     = op_t'(s_axis_tuser);
    assign in_pos    = s_axis_tdata[VALUE_W +: POS_W];
    assign front_dec = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        issue_vld_next = issue_vld_reg;
        out_vld_next   = out_vld_reg;
        value_next     = value_reg;
        addr_next      = addr_reg;
        is_pop_next    = is_pop_reg;
        res_next       = res_reg;
        st_next        = st_reg;
        out_res_next   = out_res_reg;
        out_st_next    = out_st_reg;
        out_cnt_next   = out_cnt_reg;
        rd_addr        = addr_reg;
        wr_addr        = front_dec;
        we             = 1'b0;
        s_axis_tready  = 1'b0;

        if (out_vld_reg && m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    value_next     = s_axis_tdata[VALUE_W-1:0];
                    idx_next       = '0;
                    issue_vld_next = 1'b0;
                    is_pop_next    = 1'b0;
                    unique case (in_op)
                        OP_PUSH:
                        begin
                            state_next = S_SCAN;
                        end
                        OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next   = NOT_FOUND;
                                st_next    = ST_EMPTY;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                addr_next   = wrap_add(front_reg, count_reg - 1'b1);
                                is_pop_next = 1'b1;
                                state_next  = S_READ;
                            end
                        end
                        OP_PEEK:
                        begin
                            if (PC_W'(in_pos) >= PC_W'(count_reg))
                            begin
                                res_next   = NOT_FOUND;
                                st_next    = ST_RANGE;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                addr_next  = wrap_add(front_reg, CNT_W'(in_pos));
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            res_next   = '0;
                            st_next    = ST_OK;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                rd_addr = wrap_add(front_reg, idx_reg);
                if (idx_reg < count_reg)
                begin
                    idx_next       = idx_reg + 1'b1;
                    issue_vld_next = 1'b1;
                end
                else
                begin
                    issue_vld_next = 1'b0;
                end
                if (issue_vld_reg && (rd_data_reg == value_reg))
                begin
                    res_next   = '0;
                    st_next    = ST_DUP;
                    state_next = S_DONE;
                end
                else if (!issue_vld_reg && (idx_reg >= count_reg))
                begin
                    res_next   = '0;
                    state_next = S_DONE;
                    if (count_reg == CNT_W'(DEPTH))
                    begin
                        st_next = ST_FULL;
                    end
                    else
                    begin
                        we         = 1'b1;
                        front_next = front_dec;
                        count_next = count_reg + 1'b1;
                        st_next    = ST_OK;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_LATCH;
            end
            S_LATCH:
            begin
                res_next = rd_data_reg;
                st_next  = ST_OK;
                if (is_pop_reg)
                begin
                    count_next = count_reg - 1'b1;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_vld_reg || m_axis_tready)
                begin
                    out_vld_next = 1'b1;
                    out_res_next = res_reg;
                    out_st_next  = st_reg;
                    out_cnt_next = COUNT_W'(count_reg);
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            issue_vld_reg <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            issue_vld_reg <= issue_vld_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg   <= value_next;
        addr_reg    <= addr_next;
        is_pop_reg  <= is_pop_next;
        res_reg     <= res_next;
        st_reg      <= st_next;
        out_res_reg <= out_res_next;
        out_st_reg  <= out_st_next;
        out_cnt_reg <= out_cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= value_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {(OUT_DATA_W - VALUE_W - COUNT_W)'(0), out_cnt_reg, out_res_reg};
    assign m_axis_tuser  = out_st_reg;

    // The number of held values never exceeds the store depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("held count above depth");

    // An accepted push grows the count by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        we |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push did not increment count");

    // The front pointer moves only on a memory write.
    assert property (@(posedge clk) disable iff (!rst_n)
        (front_reg != $past(front_reg)) |-> $past(we))
        else $error("front pointer moved without a write");

    // Empty and out-of-range answers always carry all ones.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && (out_st_reg == ST_EMPTY || out_st_reg == ST_RANGE))
            |-> out_res_reg == NOT_FOUND)
        else $error("error status without not-found value");

    // A duplicate is only reported while the scan compares a fetched entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && st_next == ST_DUP && state_next == S_DONE)
            |-> issue_vld_reg)
        else $error("duplicate flagged without a compared entry");

endmodule

// File: verif/unique_value_deque_tb.sv
// ----------------------------------------------------------------------------
// unique_value_deque_tb: self-checking testbench of the unique value deque
// A directed opening and about 400 random transactions are applied. Push-heavy
// and pop-heavy phases alternate so the store fills and drains. Random idle
// bursts fall on both channels, and the receiver holds off once for a long
// stretch. Every result is checked against a behavioral model of the deque.
// ----------------------------------------------------------------------------
module unique_value_deque_tb;

    import uvd_pkg::*;

    localparam int DEPTH_N = DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS = 400;
    localparam int CALM_TAIL = 60;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_OFF_AT = 150;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   pos;
    } deque_cmd_t;

    typedef struct {
        logic [VALUE_W-1:0] result;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0] count;
    } deque_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata;
    logic [OP_W-1:0]        s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic [STATUS_W-1:0]    m_axis_tuser;

    deque_cmd_t     pending_cmds[$];
    deque_result_t  expected_results[$];

    logic [VALUE_W-1:0] mirror_store[DEPTH_N];
    int             mirror_front;
    int             mirror_held;

    int             stim_total;
    int             accepted_in;
    int             results_checked;
    int             errors;
    int             idle_cycles;
    int             gap_left;
    int             stall_left;
    int             hold_left;
    logic           hold_off_done;
    logic           idling_allowed;
    int             status_seen[5];
    int             op_seen[4];

    unique_value_deque #(
        .DEPTH(DEPTH_N)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    assign idling_allowed = (accepted_in < stim_total - CALM_TAIL)
                            && ((accepted_in / 32) % 3 != 0);

    function automatic deque_result_t deque_apply(logic [OP_W-1:0] op,
                                                  logic [VALUE_W-1:0] value,
                                                  logic [POS_W-1:0] pos);
        deque_result_t r;
        logic          dup;
        r.result = '0;
        r.status = ST_OK;
        dup = 1'b0;
        if (op == OP_PUSH) begin
            for (int i = 0; i < mirror_held; i++) begin
                if (mirror_store[(mirror_front + i) % DEPTH_N] == value) begin
                    dup = 1'b1;
                end
            end
            if (dup) begin
                r.status = ST_DUP;
            end
            else if (mirror_held >= DEPTH_N) begin
                r.status = ST_FULL;
            end
            else begin
                mirror_front = (mirror_front + DEPTH_N - 1) % DEPTH_N;
                mirror_store[mirror_front] = value;
                mirror_held++;
            end
        end
        else if (op == OP_POP) begin
            if (mirror_held == 0) begin
                r.result = NOT_FOUND;
                r.status = ST_EMPTY;
            end
            else begin
                r.result = mirror_store[(mirror_front + mirror_held - 1) % DEPTH_N];
                mirror_held--;
            end
        end
        else if (op == OP_PEEK) begin
            if (int'(pos) >= mirror_held) begin
                r.result = NOT_FOUND;
                r.status = ST_RANGE;
            end
            else begin
                r.result = mirror_store[(mirror_front + int'(pos)) % DEPTH_N];
            end
        end
        r.count = COUNT_W'(mirror_held);
        return r;
    endfunction

    task automatic queue_cmd(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                             logic [POS_W-1:0] pos);
        deque_cmd_t c;
        c.op = op;
        c.value = value;
        c.pos = pos;
        pending_cmds.push_back(c);
    endtask

    // Sender: holds a transaction until it is taken, and inserts random idle bursts.
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        deque_cmd_t c;
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
            gap_left <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready) begin
            if (gap_left != 0) begin
                s_axis_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (idling_allowed && $urandom_range(0, 6) == 0) begin
                s_axis_tvalid <= 1'b0;
                gap_left <= $urandom_range(0, 10);
            end
            else if (pending_cmds.size() != 0) begin
                c = pending_cmds.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {{(IN_DATA_W - VALUE_W - POS_W){1'b0}}, c.pos, c.value};
                s_axis_tuser <= c.op;
            end
            else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stall bursts plus one long hold-off that backs up the block.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
            hold_left <= 0;
            hold_off_done <= 1'b0;
        end
        else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_off_done && results_checked >= HOLD_OFF_AT) begin
            m_axis_tready <= 1'b0;
            hold_off_done <= 1'b1;
            hold_left <= HOLD_OFF_CYCLES - 1;
        end
        else if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (idling_allowed && $urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= $urandom_range(0, 10);
        end
        else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Results are checked before the transaction of the same edge is predicted.
    always @(posedge clk)
    begin : monitor_proc
        deque_result_t want;
        deque_result_t got;
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.result = m_axis_tdata[VALUE_W-1:0];
                got.count = m_axis_tdata[VALUE_W+COUNT_W-1:VALUE_W];
                got.status = m_axis_tuser;
                if (got.status < 5) begin
                    status_seen[got.status]++;
                end
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: value %0d status %0d count %0d",
                           $signed(got.result), got.status, got.count);
                    errors++;
                end
                else begin
                    want = expected_results.pop_front();
                    if (got.result !== want.result) begin
                        $error("result_value: expected %0d, actual %0d",
                               $signed(want.result), $signed(got.result));
                        errors++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        errors++;
                    end
                    if (got.count !== want.count) begin
                        $error("entry_count: expected %0d, actual %0d", want.count, got.count);
                        errors++;
                    end
                end
                results_checked <= results_checked + 1;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                op_seen[s_axis_tuser]++;
                expected_results.push_back(deque_apply(s_axis_tuser,
                                                       s_axis_tdata[VALUE_W-1:0],
                                                       s_axis_tdata[VALUE_W+POS_W-1:VALUE_W]));
                accepted_in <= accepted_in + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : stimulus_proc
        logic [VALUE_W-1:0] corner_vals[4];
        logic [VALUE_W-1:0] value_pool[8];
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
        int                 r;
        int                 sel;
        logic               push_heavy;

        rst_n = 1'b0;
        mirror_front = 0;
        mirror_held = 0;
        accepted_in = 0;
        results_checked = 0;
        errors = 0;
        idle_cycles = 0;
        stim_total = 0;
        for (int i = 0; i < 5; i++) begin
            status_seen[i] = 0;
        end
        for (int i = 0; i < 4; i++) begin
            op_seen[i] = 0;
        end
        corner_vals[0] = 32'h8000_0000;
        corner_vals[1] = 32'h7fff_ffff;
        corner_vals[2] = 32'hffff_ffff;
        corner_vals[3] = 32'h0000_0000;
        for (int i = 0; i < 8; i++) begin
            value_pool[i] = $urandom();
        end

        // Empty store, unused code, and a held value of -1 popped back out.
        queue_cmd(OP_POP, 32'h1234_5678, 4'd0);
        queue_cmd(OP_PEEK, 32'h0, 4'd0);
        queue_cmd(OP_UNUSED, $urandom(), 4'd15);
        queue_cmd(OP_PUSH, NOT_FOUND, 4'd0);
        queue_cmd(OP_PUSH, NOT_FOUND, 4'd0);
        queue_cmd(OP_PEEK, 32'h0, 4'd0);
        queue_cmd(OP_POP, 32'h0, 4'd0);
        // Fill to capacity, then a full push and a duplicate into the full store.
        queue_cmd(OP_PUSH, corner_vals[0], 4'd0);
        queue_cmd(OP_PUSH, corner_vals[1], 4'd0);
        queue_cmd(OP_PUSH, corner_vals[3], 4'd0);
        for (int i = 0; i < DEPTH_N - 3; i++) begin
            queue_cmd(OP_PUSH, $urandom(), 4'd0);
        end
        queue_cmd(OP_PUSH, 32'h5a5a_a5a5, 4'd0);
        queue_cmd(OP_PUSH, corner_vals[1], 4'd0);
        queue_cmd(OP_PEEK, 32'h0, 4'd15);
        queue_cmd(OP_POP, 32'h0, 4'd0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            push_heavy = ((n / 50) % 2 == 0);
            r = $urandom_range(0, 99);
            if (r < (push_heavy ? 70 : 25)) begin
                op = OP_PUSH;
            end
            else if (r < (push_heavy ? 85 : 80)) begin
                op = OP_POP;
            end
            else if (r < 97) begin
                op = OP_PEEK;
            end
            else begin
                op = OP_UNUSED;
            end
            sel = $urandom_range(0, 99);
            if (op != OP_PUSH || sel < 60) begin
                value = $urandom();
            end
            else if (sel < 85) begin
                value = value_pool[$urandom_range(0, 7)];
            end
            else begin
                value = corner_vals[$urandom_range(0, 3)];
            end
            queue_cmd(op, value, POS_W'($urandom_range(0, 15)));
        end
        stim_total = pending_cmds.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_in < stim_total || expected_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d transactions in (push %0d, pop %0d, peek %0d, unused %0d)",
                 accepted_in, op_seen[OP_PUSH], op_seen[OP_POP], op_seen[OP_PEEK],
                 op_seen[OP_UNUSED]);
        $display("summary: %0d results; ok %0d dup %0d empty %0d range %0d full %0d",
                 results_checked, status_seen[ST_OK], status_seen[ST_DUP],
                 status_seen[ST_EMPTY], status_seen[ST_RANGE], status_seen[ST_FULL]);
        if (errors == 0) begin
            $display("tb: success");
        end
        else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/uvd_pkg.sv
rtl/core/unique_value_deque.sv
verif/unique_value_deque_tb.sv
